// File: rtl/page_framebuffer_pixel_engine_core_assert.svh
// assertion macros for the framebuffer pixel engine checker
`ifndef PAGE_FRAMEBUFFER_PIXEL_ENGINE_CORE_ASSERT_SVH
`define PAGE_FRAMEBUFFER_PIXEL_ENGINE_CORE_ASSERT_SVH

// property that must hold at every clock edge outside reset
`define PFB_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("pfb assertion failed");

// same-cycle implication
`define PFB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("pfb implication failed");

// next-cycle implication
`define PFB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("pfb next-cycle implication failed");

`endif

// File: rtl/pfb_pkg.sv
// shared types and constants of the framebuffer pixel engine
`timescale 1ns / 1ps

package pfb_pkg;

  localparam int unsigned PfbColumnsDef = 128;
  localparam int unsigned PfbPagesDef   = 4;

  localparam logic [7:0] PixOne  = 8'h01;
  localparam logic [7:0] PixFull = 8'hFF;

  typedef enum logic [2:0] {
    KindClear     = 3'd0,
    KindSetPixel  = 3'd1,
    KindGetPixel  = 3'd2,
    KindSetStripe = 3'd3,
    KindGetStripe = 3'd4,
    KindFill      = 3'd5
  } kind_e;

endpackage

// File: rtl/pfb_if.sv
// command and response channel interfaces
`timescale 1ns / 1ps

interface pfb_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] pixel_x;
  logic [7:0] pixel_y;
  logic [7:0] data_in;
  logic [7:0] rect_width;
  logic [7:0] rect_height;

  modport source (
    output valid, kind, pixel_x, pixel_y, data_in, rect_width, rect_height,
    input  ready
  );
  modport sink (
    input  valid, kind, pixel_x, pixel_y, data_in, rect_width, rect_height,
    output ready
  );
endinterface

interface pfb_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink (input valid, read_data, output ready);
endinterface

// File: rtl/pfb_store.sv
// frame store: byte memory, one write and one registered read port
`timescale 1ns / 1ps

module pfb_store #(
  parameter int unsigned Depth = pfb_pkg::PfbColumnsDef * pfb_pkg::PfbPagesDef
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [7:0]               wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [7:0]               rdata_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/pfb_ctrl.sv
// command sequencer: decode, read-modify-write, clear and fill sweeps, result register
`timescale 1ns / 1ps

module pfb_ctrl #(
  parameter int unsigned COLUMNS = pfb_pkg::PfbColumnsDef,
  parameter int unsigned PAGES   = pfb_pkg::PfbPagesDef,
  localparam int unsigned Depth  = COLUMNS * PAGES,
  localparam int unsigned AW     = $clog2(Depth)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  pfb_cmd_if.sink         cmd_i,
  pfb_rsp_if.source       rsp_o,
  output logic            mem_we_o,
  output logic [AW-1:0]   mem_waddr_o,
  output logic [7:0]      mem_wdata_o,
  output logic            mem_re_o,
  output logic [AW-1:0]   mem_raddr_o,
  input  logic [7:0]      mem_rdata_i
);

  localparam int unsigned Rows = PAGES * 8;
  localparam int unsigned XW   = $clog2(COLUMNS);
  localparam int unsigned PW   = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int unsigned RW   = $clog2(Rows);
  localparam int unsigned CW   = $clog2(COLUMNS + 1);
  localparam logic [AW-1:0] LastAddr = AW'(Depth - 1);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_RMW   = 6'b000100,
    ST_FILL  = 6'b001000,
    ST_FLUSH = 6'b010000,
    ST_WAIT  = 6'b100000
  } state_e;

  // constant tables for the coordinate wrap
  logic [XW-1:0] xmod_tab  [256];
  logic [PW-1:0] spage_tab [256];
  logic [PW-1:0] ppage_tab [32];

  for (genvar g = 0; g < 256; g++) begin : g_tab256
    localparam int unsigned XM = g % COLUMNS;
    localparam int unsigned SP = g % PAGES;
    assign xmod_tab[g]  = XM[XW-1:0];
    assign spage_tab[g] = SP[PW-1:0];
  end

  for (genvar g = 0; g < 32; g++) begin : g_tab32
    localparam int unsigned PP = g % PAGES;
    assign ppage_tab[g] = PP[PW-1:0];
  end

  function automatic logic [AW-1:0] byte_addr(input logic [XW-1:0] c, input logic [PW-1:0] p);
    byte_addr = AW'(c) * AW'(PAGES) + AW'(p);
  endfunction

  // bits of page pg that fall inside rows y0 .. y0+h-1, wrapping
  function automatic logic [7:0] rect_mask(input logic [PW-1:0] pg, input logic [RW-1:0] y0,
                                           input logic [7:0] h);
    logic [RW-1:0] base;
    logic [RW:0]   diff;
    logic [RW-1:0] off;
    logic          full;
    logic [7:0]    m;
    base = RW'({pg, 3'b000});
    full = (9'(h) >= 9'(Rows));
    for (int b = 0; b < 8; b++) begin
      diff = {1'b0, base | RW'(b)} - {1'b0, y0};
      off  = diff[RW] ? (diff[RW-1:0] + RW'(Rows)) : diff[RW-1:0];
      m[b] = full || (9'(off) < 9'(h));
    end
    rect_mask = m;
  endfunction

  state_e          state_q, state_d;
  logic [AW-1:0]   cnt_q, cnt_d;
  logic            clr_rsp_q, clr_rsp_d;
  pfb_pkg::kind_e  kind_q, kind_d;
  logic [AW-1:0]   addr_q, addr_d;
  logic [2:0]      bitsel_q, bitsel_d;
  logic            val_q, val_d;
  logic [XW-1:0]   col_q, col_d;
  logic [PW-1:0]   page_q, page_d;
  logic [CW-1:0]   left_q, left_d;
  logic [RW-1:0]   y0_q, y0_d;
  logic [7:0]      h_q, h_d;
  logic            wr_valid_q, wr_valid_d;
  logic [AW-1:0]   wr_addr_q, wr_addr_d;
  logic [PW-1:0]   wr_page_q, wr_page_d;
  logic [7:0]      rd_q, rd_d;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_data_q, out_data_d;

  logic [XW-1:0]   in_col;
  logic [PW-1:0]   in_ppage;
  logic [AW-1:0]   pix_addr;
  logic [AW-1:0]   stripe_addr;
  logic [CW-1:0]   ncol;
  logic [AW-1:0]   fill_addr;
  logic [7:0]      fill_mask;
  logic [7:0]      pix_mask;
  logic            fin;
  logic [7:0]      fin_data;
  logic            out_free;
  logic            out_load;
  logic [7:0]      out_next;

  assign in_col      = xmod_tab[cmd_i.pixel_x];
  assign in_ppage    = ppage_tab[cmd_i.pixel_y[7:3]];
  assign pix_addr    = byte_addr(in_col, in_ppage);
  assign stripe_addr = byte_addr(in_col, spage_tab[cmd_i.pixel_y]);
  assign ncol        = ({24'd0, cmd_i.rect_width} >= 32'(COLUMNS)) ? CW'(COLUMNS)
                                                                   : CW'(cmd_i.rect_width);
  assign fill_addr   = byte_addr(col_q, page_q);
  assign fill_mask   = rect_mask(wr_page_q, y0_q, h_q);
  assign pix_mask    = pfb_pkg::PixOne << bitsel_q;
  assign out_free    = !out_valid_q || rsp_o.ready;

  assign cmd_i.ready     = (state_q == ST_IDLE);
  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.read_data = out_data_q;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    clr_rsp_d  = clr_rsp_q;
    kind_d     = kind_q;
    addr_d     = addr_q;
    bitsel_d   = bitsel_q;
    val_d      = val_q;
    col_d      = col_q;
    page_d     = page_q;
    left_d     = left_q;
    y0_d       = y0_q;
    h_d        = h_q;
    wr_valid_d = 1'b0;
    wr_addr_d  = fill_addr;
    wr_page_d  = page_q;
    rd_d       = rd_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;
    fin        = 1'b0;
    fin_data   = '0;
    out_load   = 1'b0;
    out_next   = '0;

    unique case (state_q)
      ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = cnt_q;
        cnt_d       = cnt_q + AW'(1);
        if (cnt_q == LastAddr) begin
          // the pass after reset gives no result
          if (clr_rsp_q) begin
            fin = 1'b1;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_IDLE: begin
        if (cmd_i.valid) begin
          kind_d   = pfb_pkg::kind_e'(cmd_i.kind);
          addr_d   = pix_addr;
          bitsel_d = cmd_i.pixel_y[2:0];
          val_d    = cmd_i.data_in[0];
          state_d  = ST_RMW;
          case (pfb_pkg::kind_e'(cmd_i.kind)) inside
            pfb_pkg::KindClear: begin
              cnt_d     = '0;
              clr_rsp_d = 1'b1;
              state_d   = ST_CLEAR;
            end
            pfb_pkg::KindSetPixel, pfb_pkg::KindGetPixel: begin
              mem_re_o    = 1'b1;
              mem_raddr_o = pix_addr;
            end
            pfb_pkg::KindSetStripe: begin
              mem_we_o    = 1'b1;
              mem_waddr_o = stripe_addr;
              mem_wdata_o = cmd_i.data_in;
            end
            pfb_pkg::KindGetStripe: begin
              mem_re_o    = 1'b1;
              mem_raddr_o = stripe_addr;
            end
            pfb_pkg::KindFill: begin
              if ((cmd_i.rect_width != 8'd0) && (cmd_i.rect_height != 8'd0)) begin
                col_d   = in_col;
                page_d  = '0;
                left_d  = ncol;
                y0_d    = RW'({in_ppage, 3'b000}) | RW'(cmd_i.pixel_y[2:0]);
                h_d     = cmd_i.rect_height;
                state_d = ST_FILL;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RMW: begin
        fin = 1'b1;
        case (kind_q)
          pfb_pkg::KindSetPixel: begin
            mem_we_o    = 1'b1;
            mem_waddr_o = addr_q;
            mem_wdata_o = val_q ? (mem_rdata_i | pix_mask) : (mem_rdata_i & ~pix_mask);
          end
          pfb_pkg::KindGetPixel: fin_data = {7'd0, mem_rdata_i[bitsel_q]};
          pfb_pkg::KindGetStripe: fin_data = mem_rdata_i;
          default: ;
        endcase
      end
      ST_FILL: begin
        // read one byte per cycle, written back in the next cycle
        mem_re_o    = 1'b1;
        mem_raddr_o = fill_addr;
        wr_valid_d  = 1'b1;
        if (page_q == PW'(PAGES - 1)) begin
          page_d = '0;
          col_d  = (col_q == XW'(COLUMNS - 1)) ? '0 : col_q + XW'(1);
          left_d = left_q - CW'(1);
          if (left_q == CW'(1)) begin
            state_d = ST_FLUSH;
          end
        end else begin
          page_d = page_q + PW'(1);
        end
      end
      ST_FLUSH: begin
        fin = 1'b1;
      end
      ST_WAIT: begin
        if (out_free) begin
          out_load = 1'b1;
          out_next = rd_q;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // fill write-back stage
    if (wr_valid_q) begin
      mem_we_o    = 1'b1;
      mem_waddr_o = wr_addr_q;
      mem_wdata_o = val_q ? (mem_rdata_i | fill_mask) : (mem_rdata_i & ~fill_mask);
    end

    if (fin) begin
      if (out_free) begin
        out_load = 1'b1;
        out_next = fin_data;
        state_d  = ST_IDLE;
      end else begin
        rd_d    = fin_data;
        state_d = ST_WAIT;
      end
    end

    out_valid_d = out_load ? 1'b1 : (out_valid_q && !rsp_o.ready);
    out_data_d  = out_load ? out_next : out_data_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      clr_rsp_q   <= 1'b0;
      wr_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      clr_rsp_q   <= clr_rsp_d;
      wr_valid_q  <= wr_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    addr_q     <= addr_d;
    bitsel_q   <= bitsel_d;
    val_q      <= val_d;
    col_q      <= col_d;
    page_q     <= page_d;
    left_q     <= left_d;
    y0_q       <= y0_d;
    h_q        <= h_d;
    wr_addr_q  <= wr_addr_d;
    wr_page_q  <= wr_page_d;
    rd_q       <= rd_d;
    out_data_q <= out_data_d;
  end

endmodule

// File: rtl/page_framebuffer_pixel_engine_core.sv
// top level of the monochrome page-mode framebuffer pixel engine
`timescale 1ns / 1ps

// Monochrome COLUMNS x (PAGES*8) framebuffer held in one byte-wide synchronous
// memory, byte x*PAGES+page, bit 0 the top pixel of its page. One command per
// item on cmd_i, exactly one result per item on rsp_o (read_data is zero for
// writes). Commands run one at a time through the single, registered memory
// read port: set pixel reads, modifies and writes back its byte, get pixel and
// get stripe read it, set stripe writes it, clear writes every byte (one byte
// written per cycle), fill rectangle reads and writes back every page of
// min(width,COLUMNS) columns (one byte read and written back per cycle; zero
// width or height writes nothing). After reset a clearing pass over all
// COLUMNS*PAGES bytes runs with cmd_i.ready low. A finished result sits in an
// output register, so the next command can be taken while it waits.

module page_framebuffer_pixel_engine_core #(
  parameter int unsigned COLUMNS = pfb_pkg::PfbColumnsDef,
  parameter int unsigned PAGES   = pfb_pkg::PfbPagesDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pfb_cmd_if.sink   cmd_i,
  pfb_rsp_if.source rsp_o
);

  localparam int unsigned Depth = COLUMNS * PAGES;
  localparam int unsigned AW    = $clog2(Depth);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  pfb_ctrl #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .rsp_o       (rsp_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  pfb_store #(
    .Depth (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

// File: rtl/pfb_checker.sv
// port-level checker for the framebuffer pixel engine and its bind
`timescale 1ns / 1ps
`include "page_framebuffer_pixel_engine_core_assert.svh"

module pfb_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pend_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // items taken but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_acc && !out_acc) begin
      pend_q <= pend_q + 2'd1;
    end else if (!in_acc && out_acc) begin
      pend_q <= pend_q - 2'd1;
    end
  end

  `PFB_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `PFB_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_acc, !in_ready_i)
  `PFB_ASSERT(a_pend_bound, clk_i, rst_ni, pend_q != 2'd3)
  `PFB_ASSERT_IMP(a_no_spurious_result, clk_i, rst_ni, out_valid_i, pend_q != 2'd0)

endmodule

bind page_framebuffer_pixel_engine_core pfb_checker u_pfb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (cmd_i.valid),
  .in_ready_i  (cmd_i.ready),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready)
);

// File: sim/tb.sv
// self-checking testbench for the page-mode framebuffer pixel engine
`timescale 1ns / 1ps

module tb;

  localparam int unsigned Columns    = pfb_pkg::PfbColumnsDef;
  localparam int unsigned Pages      = pfb_pkg::PfbPagesDef;
  localparam int unsigned Rows       = Pages * 8;
  localparam int unsigned StoreBytes = Columns * Pages;

  // kinds outside the enum, the block must answer them with zero
  localparam logic [2:0] KindSpareLo = 3'd6;
  localparam logic [2:0] KindSpareHi = 3'd7;

  localparam int unsigned RandomCmds   = 1875;
  localparam int unsigned IdlePct      = 28;
  localparam int unsigned QuietSendLo  = 600;
  localparam int unsigned QuietSendHi  = 900;
  localparam int unsigned QuietRecvLo  = 1000;
  localparam int unsigned QuietRecvHi  = 1300;
  localparam int unsigned HoldAt       = 400;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned SettleCycles = 50;

  typedef struct {
    logic [2:0] kind;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] data;
    logic [7:0] width;
    logic [7:0] height;
    bit         drain_first;
  } pix_cmd_t;

  logic clk = 1'b0;
  logic rst_n;

  pfb_cmd_if cmd_if ();
  pfb_rsp_if rsp_if ();

  page_framebuffer_pixel_engine_core u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cmd_i (cmd_if),
    .rsp_o (rsp_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow copy of the frame, byte x*Pages+page, bit 0 the top pixel
  logic [7:0]  frame_bytes [StoreBytes];
  pix_cmd_t    pending_cmds [$];
  logic [7:0]  expected_reads [$];
  pix_cmd_t    offered;
  logic [7:0]  expected_read;
  int unsigned items_accepted;
  int unsigned results_seen;
  int unsigned failures;
  int unsigned hold_left;
  bit          hold_done;

  function automatic void put_pixel(input int unsigned col, input int unsigned row,
                                    input logic value);
    frame_bytes[col * Pages + row / 8][row % 8] = value;
  endfunction

  // applies one command to the shadow frame and returns the read_data it yields
  function automatic logic [7:0] run_command(input pix_cmd_t c);
    int unsigned col;
    int unsigned row;
    int unsigned stripe;
    int unsigned w_eff;
    int unsigned h_eff;
    logic [7:0]  rd;
    rd     = '0;
    col    = c.x % Columns;
    row    = c.y % Rows;
    stripe = col * Pages + c.y % Pages;
    case (c.kind)
      pfb_pkg::KindClear: begin
        for (int unsigned k = 0; k < StoreBytes; k++) frame_bytes[k] = '0;
      end
      pfb_pkg::KindSetPixel: put_pixel(col, row, c.data[0]);
      pfb_pkg::KindGetPixel: rd = {7'd0, frame_bytes[col * Pages + row / 8][row % 8]};
      pfb_pkg::KindSetStripe: frame_bytes[stripe] = c.data;
      pfb_pkg::KindGetStripe: rd = frame_bytes[stripe];
      pfb_pkg::KindFill: begin
        // wrapped pixels only get the same value again, so clamp the loops
        w_eff = (c.width > Columns) ? Columns : c.width;
        h_eff = (c.height > Rows) ? Rows : c.height;
        for (int unsigned i = 0; i < h_eff; i++)
          for (int unsigned j = 0; j < w_eff; j++)
            put_pixel((col + j) % Columns, (row + i) % Rows, c.data[0]);
      end
      default: ;
    endcase
    return rd;
  endfunction

  function automatic pix_cmd_t make_cmd(input logic [2:0] kind, input logic [7:0] x,
                                        input logic [7:0] y, input logic [7:0] data,
                                        input logic [7:0] width, input logic [7:0] height);
    pix_cmd_t c;
    c.kind        = kind;
    c.x           = x;
    c.y           = y;
    c.data        = data;
    c.width       = width;
    c.height      = height;
    c.drain_first = 1'b0;
    return c;
  endfunction

  function automatic bit sender_idles();
    if (items_accepted >= QuietSendLo && items_accepted < QuietSendHi) return 1'b0;
    return $urandom_range(99) < IdlePct;
  endfunction

  function automatic bit receiver_idles();
    if (results_seen >= QuietRecvLo && results_seen < QuietRecvHi) return 1'b0;
    return $urandom_range(99) < IdlePct;
  endfunction

  // command driver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      cmd_if.valid       <= 1'b0;
      cmd_if.kind        <= '0;
      cmd_if.pixel_x     <= '0;
      cmd_if.pixel_y     <= '0;
      cmd_if.data_in     <= '0;
      cmd_if.rect_width  <= '0;
      cmd_if.rect_height <= '0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        expected_reads.push_back(run_command(offered));
        items_accepted++;
      end
      if (!cmd_if.valid || cmd_if.ready) begin
        if (pending_cmds.size() != 0 &&
            !(pending_cmds[0].drain_first && expected_reads.size() != 0) &&
            !sender_idles()) begin
          offered = pending_cmds.pop_front();
          cmd_if.valid       <= 1'b1;
          cmd_if.kind        <= offered.kind;
          cmd_if.pixel_x     <= offered.x;
          cmd_if.pixel_y     <= offered.y;
          cmd_if.data_in     <= offered.data;
          cmd_if.rect_width  <= offered.width;
          cmd_if.rect_height <= offered.height;
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and checker
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        results_seen++;
        if (expected_reads.size() == 0) begin
          $display("%0t: result with nothing expected, read_data %02h", $time,
                   rsp_if.read_data);
          failures++;
        end else begin
          expected_read = expected_reads.pop_front();
          if (rsp_if.read_data !== expected_read) begin
            $display("%0t: read_data mismatch, expected %02h, got %02h", $time,
                     expected_read, rsp_if.read_data);
            failures++;
          end
        end
      end
      // long hold-off so the block backs up and stalls its command side
      if (hold_left != 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (results_seen == HoldAt && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HoldCycles - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= !receiver_idles();
      end
    end
  end

  initial begin
    pix_cmd_t    c;
    logic [7:0]  last_x;
    logic [7:0]  last_y;
    int unsigned pick;

    rst_n              = 1'b0;
    cmd_if.valid       = 1'b0;
    cmd_if.kind        = '0;
    cmd_if.pixel_x     = '0;
    cmd_if.pixel_y     = '0;
    cmd_if.data_in     = '0;
    cmd_if.rect_width  = '0;
    cmd_if.rect_height = '0;
    rsp_if.ready       = 1'b0;
    items_accepted     = 0;
    results_seen       = 0;
    failures           = 0;
    hold_left          = 0;
    hold_done          = 1'b0;
    last_x             = '0;
    last_y             = '0;
    for (int unsigned k = 0; k < StoreBytes; k++) frame_bytes[k] = '0;

    // directed: reset contents, wrap aliases, pixel bit 0 only, spare kinds,
    // rectangle wrap, empty rectangles, full-screen fill, clear
    pending_cmds.push_back(make_cmd(pfb_pkg::KindGetStripe, 8'd0, 8'd0, 8'h00, 8'd0, 8'd0));
    pending_cmds.push_back(make_cmd(pfb_pkg::KindSetPixel, 8'd0, 8'd0, pfb_pkg::PixOne,
                                    8'd0, 8'd0));
    pending_cmds.push_back(make_cmd(pfb_pkg::KindGetPixel, 8'd0, 8'd0, 8'h00, 8'd0, 8'd0));
    pending_cmds.push_back(make_cmd(pfb_pkg::KindSetPixel, 8'd255, 8'd255, pfb_pkg::PixFull,
                                    8'd0, 8'd0));
    pending_cmds.push_back(make_cmd(pfb_pkg::KindGetStripe, 8'd127, 8'd3, 8'h00, 8'd0, 8'd0));
    pending_cmds.push_back(make_cmd(pfb_pkg::KindSetPixel, 8'd255, 8'd255, 8'hFE, 8'd0, 8'd0));
    pending_cmds.push_back(make_cmd(pfb_pkg::KindGetPixel, 8'd127, 8'd31, 8'h00, 8'd0, 8'd0));
    pending_cmds.push_back(make_cmd(pfb_pkg::KindSetStripe, 8'd5, 8'd6, 8'hA5, 8'd0, 8'd0));
    pending_cmds.push_back(make_cmd(pfb_pkg::KindGetStripe, 8'd133, 8'd2, 8'h00, 8'd0, 8'd0));
    pending_cmds.push_back(make_cmd(pfb_pkg::KindGetPixel, 8'd5, 8'd16, 8'h00, 8'd0, 8'd0));
    pending_cmds.push_back(make_cmd(KindSpareLo, 8'd255, 8'd255, 8'hFF, 8'd255, 8'd255));
    pending_cmds.push_back(make_cmd(KindSpareHi, 8'd255, 8'd255, 8'hFF, 8'd255, 8'd255));
    pending_cmds.push_back(make_cmd(pfb_pkg::KindFill, 8'd120, 8'd28, pfb_pkg::PixOne,
                                    8'd16, 8'd8));
    pending_cmds.push_back(make_cmd(pfb_pkg::KindGetStripe, 8'd127, 8'd3, 8'h00, 8'd0, 8'd0));
    pending_cmds.push_back(make_cmd(pfb_pkg::KindGetStripe, 8'd0, 8'd0, 8'h00, 8'd0, 8'd0));
    pending_cmds.push_back(make_cmd(pfb_pkg::KindGetStripe, 8'd7, 8'd3, 8'h00, 8'd0, 8'd0));
    pending_cmds.push_back(make_cmd(pfb_pkg::KindFill, 8'd40, 8'd0, pfb_pkg::PixOne,
                                    8'd0, 8'd5));
    pending_cmds.push_back(make_cmd(pfb_pkg::KindFill, 8'd40, 8'd0, pfb_pkg::PixOne,
                                    8'd5, 8'd0));
    pending_cmds.push_back(make_cmd(pfb_pkg::KindGetStripe, 8'd40, 8'd0, 8'h00, 8'd0, 8'd0));
    pending_cmds.push_back(make_cmd(pfb_pkg::KindFill, 8'd0, 8'd0, pfb_pkg::PixFull,
                                    8'd255, 8'd255));
    pending_cmds.push_back(make_cmd(pfb_pkg::KindGetStripe, 8'd64, 8'd1, 8'h00, 8'd0, 8'd0));
    pending_cmds.push_back(make_cmd(pfb_pkg::KindFill, 8'd0, 8'd0, 8'hFE, 8'd3, 8'd3));
    pending_cmds.push_back(make_cmd(pfb_pkg::KindGetStripe, 8'd0, 8'd0, 8'h00, 8'd0, 8'd0));
    pending_cmds.push_back(make_cmd(pfb_pkg::KindClear, 8'd0, 8'd0, 8'h00, 8'd0, 8'd0));
    pending_cmds.push_back(make_cmd(pfb_pkg::KindGetStripe, 8'd127, 8'd3, 8'h00, 8'd0, 8'd0));

    // random: writes spread over the frame, reads often hitting the last write
    for (int unsigned n = 0; n < RandomCmds; n++) begin
      pick = $urandom_range(99);
      c = make_cmd(pfb_pkg::KindClear, 8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)));
      if (pick < 2) c.kind = pfb_pkg::KindClear;
      else if (pick < 22) c.kind = pfb_pkg::KindSetPixel;
      else if (pick < 40) c.kind = pfb_pkg::KindGetPixel;
      else if (pick < 55) c.kind = pfb_pkg::KindSetStripe;
      else if (pick < 70) c.kind = pfb_pkg::KindGetStripe;
      else if (pick < 94) c.kind = pfb_pkg::KindFill;
      else c.kind = ($urandom_range(1) != 0) ? KindSpareHi : KindSpareLo;

      if (c.kind == pfb_pkg::KindGetPixel || c.kind == pfb_pkg::KindGetStripe) begin
        if ($urandom_range(1) != 0) begin
          // same coordinates through a wrapped alias
          c.x = last_x ^ {$urandom_range(1) != 0, 7'd0};
          c.y = last_y + 8'(32 * $urandom_range(7));
        end
      end else if (c.kind == pfb_pkg::KindFill) begin
        // wide rectangles are slow, keep most of them narrow
        if ($urandom_range(99) >= 5) c.width = 8'($urandom_range(10));
        if ($urandom_range(1) != 0) c.height = 8'($urandom_range(12));
      end
      if (c.kind == pfb_pkg::KindSetPixel || c.kind == pfb_pkg::KindSetStripe ||
          c.kind == pfb_pkg::KindFill) begin
        last_x = c.x;
        last_y = c.y;
      end
      c.drain_first = (n == 0 || n == 900 || n == 1500);
      pending_cmds.push_back(c);
    end

    repeat (5) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    while (pending_cmds.size() != 0 || cmd_if.valid) @(posedge clk);
    while (expected_reads.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);

    if (failures == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("%0t: timeout, %0d results still expected", $time, expected_reads.size());
    $display("tb: FAIL");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/pfb_pkg.sv
rtl/pfb_if.sv
rtl/pfb_store.sv
rtl/pfb_ctrl.sv
rtl/page_framebuffer_pixel_engine_core.sv
rtl/pfb_checker.sv
sim/tb.sv
